/* sv/lzd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared constants and types of the LZ literal-run decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 4096;

  localparam logic [7:0]  LIT_FLAG  = 8'h80;
  localparam logic [6:0]  LIT_MASK  = 7'h7F;
  localparam logic [10:0] DIST_MASK = 11'h7FF;
  localparam logic [11:0] DIST_BIAS = 12'd4;
  localparam logic [3:0]  LEN_MASK  = 4'hF;
  localparam logic [4:0]  LEN_BIAS  = 5'd2;

  typedef enum logic [1:0] {
    PH_COMMAND = 2'd0,
    PH_LITERAL = 2'd1,
    PH_SECOND  = 2'd2
  } phase_e;

endpackage

/* sv/lzd_history_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_history_ram
// History memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lzd_history_ram #(
  parameter int unsigned HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lz_literal_run_decompressor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_literal_run_decompressor_unit
// Decodes literal runs and back references against a byte history memory.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  cfg      in         cfg_we_i                  cfg_wdata_i (total_blocks)
//  in       in         in_valid_i / in_stall_o   in_byte_i, start_of_stream_i
//  out      out        out_valid_o / out_stall_i out_byte_o, byte_valid_o,
//                                                last_o, done_res_o
//
//  A command or literal item is taken in S_IDLE without leaving that state.
//  A back reference emits its 2 to 17 bytes one at a time, each by a history
//  read (S_RD), then write back and output (S_WR); S_WR waits on a stalled output.
//  Reset and restart use a fill mark instead of clearing the history memory.
//  A stalled output register holds off the next item.
// ----------------------------------------------------------------------------
module lz_literal_run_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        start_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_o,
  output logic        done_res_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR
  } state_e;

  state_e          state_q, state_d;
  lzd_pkg::phase_e phase_q, phase_d;
  logic [31:0]     total_q, total_d;
  logic [31:0]     blocks_q, blocks_d;
  logic [6:0]      lit_q, lit_d;
  logic [7:0]      pend_q, pend_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic            full_q, full_d;
  logic [AW-1:0]   rd_q, rd_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            copy_done_q, copy_done_d;
  logic            rvalid_q, rvalid_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            byte_valid_q, byte_valid_d;
  logic            last_q, last_d;
  logic            done_res_q, done_res_d;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata, mem_rdata;

  logic            in_acc, out_free;
  lzd_pkg::phase_e ph_e;
  logic [31:0]     blk_e, blk_m1;
  logic [AW-1:0]   wp_e, wp_inc;
  logic            full_e, wp_wrap;
  logic [11:0]     ref_dist;
  logic [AW:0]     diff;
  logic [AW:0]     src_w;
  logic [6:0]      lit_m1;
  logic [7:0]      copy_byte;
  logic            copy_last;

  lzd_history_ram #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(rd_q),
    .rdata_o(mem_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ph_e   = start_of_stream_i ? lzd_pkg::PH_COMMAND : phase_q;
  assign blk_e  = start_of_stream_i ? total_q : blocks_q;
  assign wp_e   = start_of_stream_i ? '0 : wp_q;
  assign full_e = start_of_stream_i ? 1'b0 : full_q;
  assign blk_m1 = blk_e - 32'd1;
  assign lit_m1 = lit_q - 7'd1;

  assign wp_wrap = (wp_e == LAST_POS);
  assign wp_inc  = wp_wrap ? '0 : wp_e + AW'(1);

  assign ref_dist = {1'b0, pend_q[2:0] & lzd_pkg::DIST_MASK[10:8],
                     in_byte_i & lzd_pkg::DIST_MASK[7:0]} + lzd_pkg::DIST_BIAS;
  assign diff  = {1'b0, wp_e} - (AW + 1)'(ref_dist);
  assign src_w = diff[AW] ? diff + (AW + 1)'(HISTORY_DEPTH) : diff;

  assign copy_byte = rvalid_q ? mem_rdata : 8'd0;
  assign copy_last = (cnt_q == 5'd1);

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    total_d      = cfg_we_i ? cfg_wdata_i : total_q;
    blocks_d     = blocks_q;
    lit_d        = lit_q;
    pend_d       = pend_q;
    wp_d         = wp_q;
    full_d       = full_q;
    rd_d         = rd_q;
    cnt_d        = cnt_q;
    copy_done_d  = copy_done_q;
    rvalid_d     = rvalid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    last_d       = last_q;
    done_res_d   = done_res_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = wp_q;
    mem_wdata    = in_byte_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          phase_d  = ph_e;
          blocks_d = blk_e;
          wp_d     = wp_e;
          full_d   = full_e;
          if (start_of_stream_i) begin
            lit_d  = '0;
            pend_d = '0;
          end
          if (blk_e != 32'd0) begin
            unique case (ph_e)
              lzd_pkg::PH_LITERAL: begin
                mem_we       = 1'b1;
                mem_waddr    = wp_e;
                mem_wdata    = in_byte_i;
                wp_d         = wp_inc;
                full_d       = full_e || wp_wrap;
                lit_d        = lit_m1;
                out_valid_d  = 1'b1;
                out_byte_d   = in_byte_i;
                byte_valid_d = 1'b1;
                last_d       = 1'b1;
                done_res_d   = 1'b0;
                if (lit_m1 == 7'd0) begin
                  phase_d    = lzd_pkg::PH_COMMAND;
                  blocks_d   = blk_m1;
                  done_res_d = (blk_m1 == 32'd0);
                end
              end
              lzd_pkg::PH_SECOND: begin
                phase_d     = lzd_pkg::PH_COMMAND;
                lit_d       = '0;
                blocks_d    = blk_m1;
                copy_done_d = (blk_m1 == 32'd0);
                rd_d        = src_w[AW-1:0];
                cnt_d       = {1'b0, pend_q[6:3] & lzd_pkg::LEN_MASK} + lzd_pkg::LEN_BIAS;
                state_d     = S_RD;
              end
              default: begin
                if (in_byte_i >= lzd_pkg::LIT_FLAG) begin
                  lit_d = in_byte_i[6:0] & lzd_pkg::LIT_MASK;
                  if ((in_byte_i[6:0] & lzd_pkg::LIT_MASK) == 7'd0) begin
                    phase_d  = lzd_pkg::PH_COMMAND;
                    blocks_d = blk_m1;
                    if (blk_m1 == 32'd0) begin
                      out_valid_d  = 1'b1;
                      out_byte_d   = 8'd0;
                      byte_valid_d = 1'b0;
                      last_d       = 1'b1;
                      done_res_d   = 1'b1;
                    end
                  end else begin
                    phase_d = lzd_pkg::PH_LITERAL;
                  end
                end else begin
                  pend_d  = in_byte_i;
                  phase_d = lzd_pkg::PH_SECOND;
                end
              end
            endcase
          end
        end
      end
      S_RD: begin
        mem_re   = 1'b1;
        rvalid_d = full_q || (rd_q < wp_q);
        state_d  = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          mem_we       = 1'b1;
          mem_waddr    = wp_q;
          mem_wdata    = copy_byte;
          wp_d         = (wp_q == LAST_POS) ? '0 : wp_q + AW'(1);
          full_d       = full_q || (wp_q == LAST_POS);
          rd_d         = (rd_q == LAST_POS) ? '0 : rd_q + AW'(1);
          cnt_d        = cnt_q - 5'd1;
          out_valid_d  = 1'b1;
          out_byte_d   = copy_byte;
          byte_valid_d = 1'b1;
          last_d       = copy_last;
          done_res_d   = copy_last && copy_done_q;
          state_d      = copy_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= lzd_pkg::PH_COMMAND;
      total_q     <= '0;
      blocks_q    <= '0;
      lit_q       <= '0;
      pend_q      <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      total_q     <= total_d;
      blocks_q    <= blocks_d;
      lit_q       <= lit_d;
      pend_q      <= pend_d;
      wp_q        <= wp_d;
      full_q      <= full_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q         <= rd_d;
    copy_done_q  <= copy_done_d;
    rvalid_q     <= rvalid_d;
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    last_q       <= last_d;
    done_res_q   <= done_res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign last_o       = last_q;
  assign done_res_o   = done_res_q;

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("History read and write in the same cycle.");

  a_copy_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cnt_q != 5'd0))
    else $error("Copy in progress with no bytes left.");

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_res_q) |-> (last_q && (blocks_q == 32'd0)))
    else $error("Final block marker without last item or with blocks left.");

  a_marker_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !byte_valid_q) |-> (done_res_q && (out_byte_q == 8'd0)))
    else $error("Bare marker item is malformed.");

  a_copy_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && !copy_last && out_free) |=> (state_q == S_RD))
    else $error("Copy sequencer left the read step.");

endmodule

/* tb/sv/lz_literal_run_decompressor_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_literal_run_decompressor_unit_tb
// Self-checking testbench for the LZ literal-run decompressor. A directed table
// covers idle bytes, literal runs, empty runs, far and overlapping back
// references and restarts. Random phases follow, with several block counts and
// random pauses on both channels. Results are checked against a behavioral
// decoder that tracks its own history and block count, or against table rows.
// ----------------------------------------------------------------------------
module lz_literal_run_decompressor_unit_tb;

  localparam int HIST_DEPTH   = lzd_pkg::HISTORY_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_WAIT  = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAB_ROWS     = 25;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       last;
    logic       done;
  } res_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_chk_e;

  typedef struct packed {
    logic [7:0] in_b;
    logic       sos;
    row_chk_e   chk;
    res_t       res;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [TAB_ROWS] = '{
    '{8'h85, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h82, 1'b1, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, CHK_ONE,   '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{8'h00, 1'b0, CHK_ONE,   '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'h80, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h7F, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, CHK_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, CHK_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h81, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'hA5, 1'b0, CHK_ONE,   '{8'hA5, 1'b1, 1'b1, 1'b1}},
    '{8'h80, 1'b1, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h83, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h11, 1'b0, CHK_ONE,   '{8'h11, 1'b1, 1'b1, 1'b0}},
    '{8'h22, 1'b0, CHK_ONE,   '{8'h22, 1'b1, 1'b1, 1'b0}},
    '{8'h33, 1'b0, CHK_ONE,   '{8'h33, 1'b1, 1'b1, 1'b0}},
    '{8'h18, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, CHK_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h80, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h80, 1'b0, CHK_ONE,   '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{8'h55, 1'b0, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h82, 1'b1, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h44, 1'b0, CHK_ONE,   '{8'h44, 1'b1, 1'b1, 1'b0}},
    '{8'h01, 1'b1, CHK_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, CHK_MODEL, '{8'h00, 1'b0, 1'b0, 1'b0}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        start_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        last_o;
  logic        done_res_o;

  lz_literal_run_decompressor_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_byte_i         (in_byte_i),
    .start_of_stream_i (start_of_stream_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .byte_valid_o      (byte_valid_o),
    .last_o            (last_o),
    .done_res_o        (done_res_o)
  );

  // Decoder state.
  lzd_pkg::phase_e dec_phase = lzd_pkg::PH_COMMAND;
  logic [6:0]  run_left = '0;
  logic [7:0]  ref_cmd = '0;
  logic [7:0]  hist_mem [HIST_DEPTH];
  int          hist_wr = 0;
  logic [31:0] blocks_rem = '0;
  logic [31:0] cfg_total = '0;

  res_t        step_q[$];
  res_t        pending_q[$];
  bit          item_ignored;
  bit          hold_req = 1'b0;
  bit          tx_gaps_on = 1'b1;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          items_live = 0;
  int          items_idle = 0;
  int          results_seen = 0;
  int          restarts = 0;
  int          streams_done = 0;
  int          hist_wraps = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void hist_store(input logic [7:0] v);
    hist_mem[hist_wr] = v;
    hist_wr = (hist_wr + 1) % HIST_DEPTH;
    if (hist_wr == 0) hist_wraps++;
  endfunction

  function automatic logic close_block();
    dec_phase = lzd_pkg::PH_COMMAND;
    run_left = '0;
    if (blocks_rem != 0) blocks_rem--;
    if (blocks_rem == 0) streams_done++;
    return blocks_rem == 0;
  endfunction

  function automatic void decode_item(input logic [7:0] b, input logic sos);
    int   copy_dist;
    int   len;
    logic fin;
    logic [7:0] v;
    step_q.delete();
    item_ignored = 1'b0;
    if (sos) begin
      dec_phase = lzd_pkg::PH_COMMAND;
      run_left = '0;
      ref_cmd = '0;
      foreach (hist_mem[i]) hist_mem[i] = '0;
      hist_wr = 0;
      blocks_rem = cfg_total;
      restarts++;
    end
    if (blocks_rem == 0) begin
      item_ignored = 1'b1;
      return;
    end
    case (dec_phase)
      lzd_pkg::PH_LITERAL: begin
        hist_store(b);
        run_left = run_left - 7'd1;
        fin = 1'b0;
        if (run_left == 0) fin = close_block();
        step_q.push_back('{b, 1'b1, 1'b1, fin});
      end
      lzd_pkg::PH_SECOND: begin
        copy_dist = int'({ref_cmd[2:0], b} & lzd_pkg::DIST_MASK) + int'(lzd_pkg::DIST_BIAS);
        len = int'(ref_cmd[6:3] & lzd_pkg::LEN_MASK) + int'(lzd_pkg::LEN_BIAS);
        fin = close_block();
        for (int i = 0; i < len; i++) begin
          v = hist_mem[(hist_wr + HIST_DEPTH - copy_dist) % HIST_DEPTH];
          hist_store(v);
          step_q.push_back('{v, 1'b1, i == len - 1, (i == len - 1) && fin});
        end
      end
      default: begin
        if (b >= lzd_pkg::LIT_FLAG) begin
          run_left = b[6:0] & lzd_pkg::LIT_MASK;
          if (run_left == 0) begin
            if (close_block()) step_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
          end else begin
            dec_phase = lzd_pkg::PH_LITERAL;
          end
        end else begin
          ref_cmd = b;
          dec_phase = lzd_pkg::PH_SECOND;
        end
      end
    endcase
  endfunction

  task automatic tx_pause();
    int n;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic sos, input row_chk_e chk,
                           input res_t typed);
    tx_pause();
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    start_of_stream_i <= sos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_item(b, sos);
    if (item_ignored) items_idle++;
    else items_live++;
    case (chk)
      CHK_MODEL: foreach (step_q[i]) pending_q.push_back(step_q[i]);
      CHK_ONE:   pending_q.push_back(typed);
      default:   ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sos);
    send_item(b, sos, CHK_MODEL, '0);
  endtask

  task automatic settle_and_write(input logic [31:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_total = v;
  endtask

  // Well-formed blocks with random content, mixed with stray restarts and
  // junk bytes. The long mode keeps one stream alive past a history wrap.
  task automatic run_random(input int n_items, input bit long_mode);
    int         base;
    int         kind;
    int         len;
    bit         restart_next;
    bit         held;
    logic [7:0] cmd;
    logic [7:0] b2;
    base = items_live;
    restart_next = 1'b1;
    held = 1'b0;
    while (long_mode ? !(hist_wraps > 0 && items_live - base >= 300)
                     : (items_live - base < n_items)) begin
      if (items_live - base >= 64 && (items_live - base) % 64 == 0)
        tx_gaps_on = ($urandom_range(0, 2) != 0);
      if (long_mode && !held && items_live - base >= 40) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (blocks_rem == 0 && !restart_next) begin
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
        restart_next = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (long_mode) kind = (kind < 97) ? 50 : 10;
      if (kind < 42) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
        if (long_mode) len = $urandom_range(1, 4);
        send_byte(lzd_pkg::LIT_FLAG | 8'(len), restart_next);
        for (int i = 0; i < len; i++)
          send_byte(8'($urandom_range(0, 255)), !long_mode && $urandom_range(0, 149) == 0);
      end else if (kind < 88) begin
        cmd = long_mode ? 8'($urandom_range(8'h78, 8'h7F)) : 8'($urandom_range(0, 8'h7F));
        b2 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) begin
          cmd[2:0] = 3'd0;
          b2 = 8'($urandom_range(0, 15));
        end
        send_byte(cmd, restart_next);
        send_byte(b2, !long_mode && $urandom_range(0, 149) == 0);
      end else if (kind < 94) begin
        send_byte(lzd_pkg::LIT_FLAG, restart_next);
      end else begin
        send_byte(8'($urandom_range(0, 255)), restart_next | 1'($urandom_range(0, 1)));
      end
      restart_next = 1'b0;
    end
  endtask

  // Receiver: random stall gaps, quiet stretches, and one long hold-off.
  initial begin
    int gap_left;
    int rx_cyc;
    bit rx_gaps_on;
    gap_left = 0;
    rx_cyc = 0;
    rx_gaps_on = 1'b1;
    forever begin
      @(negedge clk_i);
      rx_cyc++;
      if (rx_cyc % 300 == 0) rx_gaps_on = ($urandom_range(0, 2) != 0);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (gap_left > 0) begin
        out_stall_i <= 1'b1;
        gap_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (rx_gaps_on && $urandom_range(0, 3) == 0)
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_byte_o, byte_valid_o, last_o, done_res_o};
      results_seen++;
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("Unexpected result: byte %02h valid %0b last %0b done %0b",
                   got.value, got.valid, got.last, got.done);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("Mismatch on result %0d: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                     results_seen, want.value, want.valid, want.last, want.done,
                     got.value, got.valid, got.last, got.done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_cnt, pending_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    foreach (hist_mem[i]) hist_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    settle_and_write(32'd5);
    for (int r = 0; r < TAB_ROWS; r++)
      send_item(DIR_TAB[r].in_b, DIR_TAB[r].sos, DIR_TAB[r].chk, DIR_TAB[r].res);

    settle_and_write(32'hFFFF_FFFF);
    run_random(0, 1'b1);

    settle_and_write(32'd1);
    run_random(40, 1'b0);

    settle_and_write(32'd0);
    send_byte(8'h81, 1'b1);
    for (int i = 0; i < 6; i++)
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    settle_and_write($urandom_range(2, 12));
    run_random(50, 1'b0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    err_cnt += pending_q.size();

    $display("Covered %0d decoded and %0d ignored items, %0d results, %0d restarts.",
             items_live, items_idle, results_seen, restarts);
    $display("Streams finished: %0d, history wraps: %0d, mismatches: %0d.",
             streams_done, hist_wraps, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
